// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl files of the signature matcher
// depends on a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

// ===== rtl/scm_pkg.sv =====
// shared types, codes and constants of the signature matcher
// no dependencies
package scm_pkg;

    // field widths fixed by the interface
    localparam int ACTION_W   = 2;
    localparam int OS_IDX_W   = 4;
    localparam int OFFSET_W   = 11;
    localparam int DIGEST_W   = 64;
    localparam int ENTRY_W    = 2 * DIGEST_W;
    localparam int OS_COUNT_W = 5;
    localparam int STATUS_W   = 2;
    localparam int TOTAL_W    = 5;
    localparam int MASK_W     = 16;
    localparam int HIT_W      = 11;

    localparam logic [HIT_W-1:0] HIT_MAX = '1;

    // default sizing
    localparam int DEF_NUM_VERSIONS = 16;
    localparam int DEF_NUM_PAGES    = 2048;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD    = 2'd0,
        ACT_MATCH   = 2'd1,
        ACT_RESTART = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ONE     = 2'd0,
        ST_SEVERAL = 2'd1,
        ST_GAP     = 2'd2,
        ST_NONE    = 2'd3
    } status_t;

    // commands from the front end to the scan engine
    typedef struct packed {
        logic match;
        logic restart;
    } scm_cmd_t;

    // status from the scan engine to the front end
    typedef struct packed {
        logic busy;
        logic clearing;
    } scm_stat_t;

endpackage

// ===== rtl/signature_candidate_matcher_core.sv =====
// top level of the signature matcher: command decode, config register, signature table
// depends on scm_pkg, scm_ram, scm_scan and assert_macros.svh
//
//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------------------------
//  command   | start / busy         | action, os_index, page_offset, digest_high/low
//  result    | done (one cycle)     | status, last_match_os, match_total, alive_mask,
//            |                      | leading_valid, leading_os, leading_count
//  config    | cfg_we               | cfg_wdata (os_count)
//
// a match transaction holds busy through its scan and tail states, one table and counter read
// per version on the single read port; its result strobes in the cycle after the tail state
// load and restart transactions do not raise busy and give no result
// after reset the table is zeroed, one entry a cycle, over all 2**(clog2(NUM_VERSIONS) +
// clog2(NUM_PAGES)) entries (32768 at default sizing) with busy high
// results cannot be stalled; config writes are taken in any cycle
`include "assert_macros.svh"

module signature_candidate_matcher_core
    import scm_pkg::*;
#(
    parameter int NUM_VERSIONS = DEF_NUM_VERSIONS,
    parameter int NUM_PAGES    = DEF_NUM_PAGES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [ACTION_W-1:0]   action,
    input  logic [OS_IDX_W-1:0]   os_index,
    input  logic [OFFSET_W-1:0]   page_offset,
    input  logic [DIGEST_W-1:0]   digest_high,
    input  logic [DIGEST_W-1:0]   digest_low,
    input  logic                  cfg_we,
    input  logic [OS_COUNT_W-1:0] cfg_wdata,
    output logic                  done,
    output logic [STATUS_W-1:0]   status,
    output logic [OS_IDX_W-1:0]   last_match_os,
    output logic [TOTAL_W-1:0]    match_total,
    output logic [MASK_W-1:0]     alive_mask,
    output logic                  leading_valid,
    output logic [OS_IDX_W-1:0]   leading_os,
    output logic [HIT_W-1:0]      leading_count
);

    localparam int VW  = $clog2(NUM_VERSIONS);
    localparam int PW  = $clog2(NUM_PAGES);
    localparam int TAW = VW + PW;

    logic [OS_COUNT_W-1:0] os_count_reg;
    logic                  accept;
    logic                  load_we;
    scm_cmd_t              cmd;
    scm_stat_t             stat;
    logic [TAW-1:0]        tbl_raddr, clr_addr, tbl_waddr;
    logic                  clr_we, tbl_we;
    logic [ENTRY_W-1:0]    tbl_rdata, tbl_wdata;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            os_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            os_count_reg <= cfg_wdata;
        end
    end

    // command decode
    assign accept      = start && !stat.busy;
    assign cmd.match   = accept && (action == ACT_MATCH);
    assign cmd.restart = accept && (action == ACT_RESTART);
    assign load_we     = accept && (action == ACT_LOAD)
                         && (32'(os_index) < NUM_VERSIONS) && (32'(page_offset) < NUM_PAGES);
    assign busy        = stat.busy;

    // table write port: clearing pass or load transaction
    assign tbl_we    = clr_we || load_we;
    assign tbl_waddr = clr_we ? clr_addr : {VW'(os_index), PW'(page_offset)};
    assign tbl_wdata = clr_we ? '0 : {digest_high, digest_low};

    scm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (2 ** TAW)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    scm_scan #(
        .NUM_VERSIONS (NUM_VERSIONS),
        .NUM_PAGES    (NUM_PAGES)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .page_offset   (page_offset),
        .digest_high   (digest_high),
        .digest_low    (digest_low),
        .os_count      (os_count_reg),
        .tbl_raddr     (tbl_raddr),
        .tbl_rdata     (tbl_rdata),
        .clr_we        (clr_we),
        .clr_addr      (clr_addr),
        .stat          (stat),
        .done          (done),
        .status        (status),
        .last_match_os (last_match_os),
        .match_total   (match_total),
        .alive_mask    (alive_mask),
        .leading_valid (leading_valid),
        .leading_os    (leading_os),
        .leading_count (leading_count)
    );

    // checks
    `ASSERT_NEVER(a_load_during_clear, load_we && stat.clearing, "load written during clearing pass")

endmodule

// ===== rtl/scm_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module scm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/scm_scan.sv =====
// scan engine: table clearing pass, per-version compare loop, hit counters
// depends on scm_pkg, scm_ram and assert_macros.svh
`include "assert_macros.svh"

module scm_scan
    import scm_pkg::*;
#(
    parameter int NUM_VERSIONS = DEF_NUM_VERSIONS,
    parameter int NUM_PAGES    = DEF_NUM_PAGES,
    localparam int VW  = $clog2(NUM_VERSIONS),
    localparam int PW  = $clog2(NUM_PAGES),
    localparam int TAW = VW + PW
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  scm_cmd_t              cmd,
    input  logic [OFFSET_W-1:0]   page_offset,
    input  logic [DIGEST_W-1:0]   digest_high,
    input  logic [DIGEST_W-1:0]   digest_low,
    input  logic [OS_COUNT_W-1:0] os_count,
    output logic [TAW-1:0]        tbl_raddr,
    input  logic [ENTRY_W-1:0]    tbl_rdata,
    output logic                  clr_we,
    output logic [TAW-1:0]        clr_addr,
    output scm_stat_t             stat,
    output logic                  done,
    output logic [STATUS_W-1:0]   status,
    output logic [OS_IDX_W-1:0]   last_match_os,
    output logic [TOTAL_W-1:0]    match_total,
    output logic [MASK_W-1:0]     alive_mask,
    output logic                  leading_valid,
    output logic [OS_IDX_W-1:0]   leading_os,
    output logic [HIT_W-1:0]      leading_count
);

    localparam int CW = $clog2(NUM_VERSIONS + 1);
    localparam logic [VW-1:0]  LAST_VER  = VW'(NUM_VERSIONS - 1);
    localparam logic [TAW-1:0] LAST_ADDR = '1;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_TAIL} state_t;

    state_t                    state_reg, state_next;
    logic [TAW-1:0]            clr_addr_reg, clr_addr_next;
    logic [VW-1:0]             rd_idx_reg, rd_idx_next;
    logic                      s1_vld_reg, s1_vld_next;
    logic [VW-1:0]             s1_idx_reg, s1_idx_next;
    logic [PW-1:0]             off_reg, off_next;
    logic                      inrange_reg, inrange_next;
    logic [ENTRY_W-1:0]        dig_reg, dig_next;
    logic [NUM_VERSIONS-1:0]   live_reg, live_next;
    logic [NUM_VERSIONS-1:0]   hit_vld_reg, hit_vld_next;
    logic [CW-1:0]             match_cnt_reg, match_cnt_next;
    logic                      gap_reg, gap_next;
    logic [NUM_VERSIONS-1:0]   drop_reg, drop_next;
    logic [VW-1:0]             last_reg, last_next;
    logic [VW-1:0]             lead_os_reg, lead_os_next;
    logic [HIT_W-1:0]          lead_cnt_reg, lead_cnt_next;
    logic                      done_reg, done_next;
    status_t                   status_reg, status_next;
    logic [OS_IDX_W-1:0]       last_out_reg, last_out_next;
    logic [TOTAL_W-1:0]        total_reg, total_next;
    logic [MASK_W-1:0]         alive_reg, alive_next;
    logic                      lvalid_reg, lvalid_next;
    logic [OS_IDX_W-1:0]       los_reg, los_next;
    logic [HIT_W-1:0]          lcnt_reg, lcnt_next;

    logic [HIT_W-1:0]          hit_rdata;
    logic                      base, ent_zero, ent_eq;
    logic                      is_gap, is_hit, is_miss;
    logic [HIT_W-1:0]          cnt_old, cnt_new;
    logic [CW-1:0]             match_fin;
    logic                      gap_fin;
    logic [NUM_VERSIONS-1:0]   drop_fin, live_fin;
    logic [VW-1:0]             last_fin, lead_os_fin;
    logic [HIT_W-1:0]          lead_cnt_fin;
    logic                      final_step;

    // hit counters, one entry per version, written back in the cycle after the read
    scm_ram #(
        .WIDTH (HIT_W),
        .DEPTH (NUM_VERSIONS)
    ) u_hits (
        .clk   (clk),
        .we    (s1_vld_reg),
        .waddr (s1_idx_reg),
        .wdata (cnt_new),
        .raddr (rd_idx_reg),
        .rdata (hit_rdata)
    );

    // compare stage on the data read in the previous cycle
    always_comb
    begin
        base     = s1_vld_reg && (32'(s1_idx_reg) < 32'(os_count)) && live_reg[s1_idx_reg];
        ent_zero = (tbl_rdata == '0);
        ent_eq   = (tbl_rdata == dig_reg);
        is_gap   = base && (!inrange_reg || ent_zero);
        is_hit   = base && inrange_reg && !ent_zero && ent_eq;
        is_miss  = base && inrange_reg && !ent_zero && !ent_eq;
        cnt_old  = hit_vld_reg[s1_idx_reg] ? hit_rdata : '0;
        cnt_new  = (is_hit && (cnt_old != HIT_MAX)) ? cnt_old + HIT_W'(1) : cnt_old;

        match_fin = match_cnt_reg + CW'(is_hit);
        gap_fin   = gap_reg || is_gap;
        drop_fin  = drop_reg | (is_miss ? (NUM_VERSIONS'(1) << s1_idx_reg) : '0);
        last_fin  = is_hit ? s1_idx_reg : last_reg;

        // strict compare keeps the lowest index on ties
        if (s1_vld_reg && (cnt_new > lead_cnt_reg))
        begin
            lead_os_fin  = s1_idx_reg;
            lead_cnt_fin = cnt_new;
        end
        else
        begin
            lead_os_fin  = lead_os_reg;
            lead_cnt_fin = lead_cnt_reg;
        end

        live_fin   = (match_fin != '0) ? (live_reg & ~drop_fin) : live_reg;
        final_step = s1_vld_reg && (s1_idx_reg == LAST_VER);
    end

    // next-state logic
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        rd_idx_next    = rd_idx_reg;
        s1_vld_next    = 1'b0;
        s1_idx_next    = s1_idx_reg;
        off_next       = off_reg;
        inrange_next   = inrange_reg;
        dig_next       = dig_reg;
        live_next      = live_reg;
        hit_vld_next   = hit_vld_reg;
        match_cnt_next = match_cnt_reg;
        gap_next       = gap_reg;
        drop_next      = drop_reg;
        last_next      = last_reg;
        lead_os_next   = lead_os_reg;
        lead_cnt_next  = lead_cnt_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        last_out_next  = last_out_reg;
        total_next     = total_reg;
        alive_next     = alive_reg;
        lvalid_next    = lvalid_reg;
        los_next       = los_reg;
        lcnt_next      = lcnt_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + TAW'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd.restart)
                begin
                    live_next    = '1;
                    hit_vld_next = '0;
                end
                else if (cmd.match)
                begin
                    off_next       = PW'(page_offset);
                    inrange_next   = (32'(page_offset) < NUM_PAGES);
                    dig_next       = {digest_high, digest_low};
                    rd_idx_next    = '0;
                    match_cnt_next = '0;
                    gap_next       = 1'b0;
                    drop_next      = '0;
                    last_next      = '0;
                    lead_os_next   = '0;
                    lead_cnt_next  = '0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                s1_vld_next = 1'b1;
                s1_idx_next = rd_idx_reg;
                rd_idx_next = rd_idx_reg + VW'(1);
                if (rd_idx_reg == LAST_VER)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                state_next = S_IDLE;
            end
        endcase

        // accumulate over the compare stage
        if (s1_vld_reg)
        begin
            hit_vld_next[s1_idx_reg] = 1'b1;
            match_cnt_next = match_fin;
            gap_next       = gap_fin;
            drop_next      = drop_fin;
            last_next      = last_fin;
            lead_os_next   = lead_os_fin;
            lead_cnt_next  = lead_cnt_fin;
        end

        // last version seen: settle the live mask and load the result registers
        if (final_step)
        begin
            live_next     = live_fin;
            done_next     = 1'b1;
            last_out_next = OS_IDX_W'(last_fin);
            total_next    = TOTAL_W'(match_fin);
            alive_next    = MASK_W'(live_fin);
            lvalid_next   = (lead_cnt_fin != '0);
            los_next      = OS_IDX_W'(lead_os_fin);
            lcnt_next     = lead_cnt_fin;
            priority if (match_fin == CW'(1))
            begin
                status_next = ST_ONE;
            end
            else if (match_fin != '0)
            begin
                status_next = ST_SEVERAL;
            end
            else if (gap_fin)
            begin
                status_next = ST_GAP;
            end
            else
            begin
                status_next = ST_NONE;
            end
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            rd_idx_reg    <= '0;
            s1_vld_reg    <= 1'b0;
            s1_idx_reg    <= '0;
            off_reg       <= '0;
            inrange_reg   <= 1'b0;
            dig_reg       <= '0;
            live_reg      <= '1;
            hit_vld_reg   <= '0;
            match_cnt_reg <= '0;
            gap_reg       <= 1'b0;
            drop_reg      <= '0;
            last_reg      <= '0;
            lead_os_reg   <= '0;
            lead_cnt_reg  <= '0;
            done_reg      <= 1'b0;
            status_reg    <= ST_NONE;
            last_out_reg  <= '0;
            total_reg     <= '0;
            alive_reg     <= '0;
            lvalid_reg    <= 1'b0;
            los_reg       <= '0;
            lcnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            rd_idx_reg    <= rd_idx_next;
            s1_vld_reg    <= s1_vld_next;
            s1_idx_reg    <= s1_idx_next;
            off_reg       <= off_next;
            inrange_reg   <= inrange_next;
            dig_reg       <= dig_next;
            live_reg      <= live_next;
            hit_vld_reg   <= hit_vld_next;
            match_cnt_reg <= match_cnt_next;
            gap_reg       <= gap_next;
            drop_reg      <= drop_next;
            last_reg      <= last_next;
            lead_os_reg   <= lead_os_next;
            lead_cnt_reg  <= lead_cnt_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
            last_out_reg  <= last_out_next;
            total_reg     <= total_next;
            alive_reg     <= alive_next;
            lvalid_reg    <= lvalid_next;
            los_reg       <= los_next;
            lcnt_reg      <= lcnt_next;
        end
    end

    // table access and status
    assign tbl_raddr      = {rd_idx_reg, off_reg};
    assign clr_we         = (state_reg == S_CLEAR);
    assign clr_addr       = clr_addr_reg;
    assign stat.busy      = (state_reg != S_IDLE);
    assign stat.clearing  = (state_reg == S_CLEAR);

    assign done          = done_reg;
    assign status        = status_reg;
    assign last_match_os = last_out_reg;
    assign match_total   = total_reg;
    assign alive_mask    = alive_reg;
    assign leading_valid = lvalid_reg;
    assign leading_os    = los_reg;
    assign leading_count = lcnt_reg;

    // checks
    `ASSERT_CLK(a_done_after_tail, done_reg |-> $past(state_reg == S_TAIL), "early result")
    `ASSERT_NEVER(a_live_shrinks, (state_reg == S_TAIL) && |(live_fin & ~live_reg), "live grew")
    `ASSERT_NEVER(a_one_total, (status_reg == ST_ONE) && (total_reg != TOTAL_W'(1)), "bad total")

endmodule
